// ===== sv/lfea_pkg.sv =====
package lfea_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_OWNED = 2'd1,
        STS_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        KIND_EMPTY = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_USED  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        SCAN_LOW  = 2'd0,
        SCAN_DEL  = 2'd1,
        SCAN_READ = 2'd2
    } t_scan_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_SPLIT,
        S_DONE
    } t_state;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] file_id;
        logic [15:0] length;
        logic [31:0] sector;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] owner;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic     load;
        logic     clr_run;
        logic     scan_start;
        logic     scan_run;
        t_scan_op op;
        logic     adv;
        logic     exec_init;
        logic     wr_tail;
        logic     wr_split_a;
        logic     wr_split_b;
        logic     wr_whole;
        logic     out_load;
        t_status  out_status;
        logic     out_hit;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic scan_last;
        logic best_vld;
        logic size_gt;
        logic size_eq;
        logic tail_ovf;
        logic empty_vld;
        logic hit_vld;
        logic len_zero;
        t_cmd item_cmd;
        logic out_busy;
    } t_dp_sts;

endpackage

// ===== sv/lfea_ctrl.sv =====
module lfea_ctrl import lfea_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state  r_state, n_state;
    logic    r_exec, n_exec;
    t_status r_res, n_res;
    logic    r_res_hit, n_res_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_exec    <= 1'b0;
            r_res     <= STS_OK;
            r_res_hit <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_exec    <= n_exec;
            r_res     <= n_res;
            r_res_hit <= n_res_hit;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_exec     = r_exec;
        n_res      = r_res;
        n_res_hit  = r_res_hit;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.op   = SCAN_LOW;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_run = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                n_res     = STS_OK;
                n_res_hit = 1'b0;
                n_exec    = 1'b0;
                case (i_sts.item_cmd)
                    CMD_WRITE: begin
                        if (i_sts.len_zero) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            o_cmd.op         = SCAN_LOW;
                            n_state          = S_SCAN;
                        end
                    end
                    CMD_DELETE: begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.op         = SCAN_DEL;
                        n_state          = S_SCAN;
                    end
                    CMD_READ: begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.op         = SCAN_READ;
                        n_state          = S_SCAN;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_last) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_DECIDE;
            S_DECIDE: begin
                case (i_sts.item_cmd)
                    CMD_READ: begin
                        n_res     = i_sts.hit_vld ? STS_OK : STS_NOT_OWNED;
                        n_res_hit = i_sts.hit_vld;
                        n_state   = S_DONE;
                    end
                    CMD_WRITE: begin
                        if (!r_exec) begin
                            // feasibility walk, nothing written yet
                            if (!i_sts.best_vld) begin
                                if (i_sts.tail_ovf || !i_sts.empty_vld) begin
                                    n_res   = STS_FULL;
                                    n_state = S_DONE;
                                end else begin
                                    n_exec          = 1'b1;
                                    o_cmd.exec_init = 1'b1;
                                end
                            end else if (i_sts.size_gt || i_sts.size_eq) begin
                                if (i_sts.size_gt && !i_sts.empty_vld) begin
                                    n_res   = STS_FULL;
                                    n_state = S_DONE;
                                end else begin
                                    n_exec          = 1'b1;
                                    o_cmd.exec_init = 1'b1;
                                end
                            end else begin
                                o_cmd.adv = 1'b1;
                            end
                            if (n_state == S_DECIDE) begin
                                o_cmd.scan_start = 1'b1;
                                o_cmd.op         = SCAN_LOW;
                                n_state          = S_SCAN;
                            end
                        end else begin
                            if (!i_sts.best_vld) begin
                                o_cmd.wr_tail = 1'b1;
                                n_state       = S_DONE;
                            end else if (i_sts.size_gt) begin
                                o_cmd.wr_split_a = 1'b1;
                                n_state          = S_SPLIT;
                            end else begin
                                o_cmd.wr_whole = 1'b1;
                                if (i_sts.size_eq) begin
                                    n_state = S_DONE;
                                end else begin
                                    o_cmd.adv        = 1'b1;
                                    o_cmd.scan_start = 1'b1;
                                    o_cmd.op         = SCAN_LOW;
                                    n_state          = S_SCAN;
                                end
                            end
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SPLIT: begin
                o_cmd.wr_split_b = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = r_res;
                    o_cmd.out_hit    = r_res_hit;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== sv/lfea_dp.sv =====
module lfea_dp import lfea_pkg::*; #(
    parameter int MAX_EXTENTS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int IW = $clog2(MAX_EXTENTS);
    localparam logic [IW-1:0] LAST = IW'(MAX_EXTENTS - 1);

    // extent table
    logic [31:0] m_start [MAX_EXTENTS];
    logic [31:0] m_end   [MAX_EXTENTS];
    logic [31:0] m_owner [MAX_EXTENTS];
    t_kind       m_kind  [MAX_EXTENTS];

    logic [31:0] r_q_start, r_q_end, r_q_owner;
    t_kind       r_q_kind;

    t_in_item    r_item;
    logic [15:0] r_rem;
    logic [32:0] r_lo;
    logic [31:0] r_hw;
    t_scan_op    r_op;
    logic [IW-1:0] r_cnt;
    logic        r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic        r_best_vld;
    logic [IW-1:0] r_best_idx;
    logic [31:0] r_best_start, r_best_end;
    logic        r_empty_vld;
    logic [IW-1:0] r_empty_idx;
    logic        r_hit_vld;
    logic [31:0] r_hit_owner;
    logic        r_out_vld;
    t_out_item   r_out;

    logic [32:0] size, tail_sum, new_end;
    logic        del_hit, low_hit, emp_hit, rd_hit;

    assign size     = {1'b0, r_best_end} - {1'b0, r_best_start} + 33'd1;
    assign tail_sum = {1'b0, r_hw} + {17'd0, r_rem};
    assign new_end  = {1'b0, r_best_start} + {17'd0, r_rem} - 33'd1;

    assign del_hit = r_rd_vld && r_op == SCAN_DEL && r_q_kind == KIND_USED
                     && r_q_owner == r_item.file_id;
    assign low_hit = r_rd_vld && r_op == SCAN_LOW && r_q_kind == KIND_FREE
                     && {1'b0, r_q_start} >= r_lo
                     && (!r_best_vld || r_q_start < r_best_start);
    assign emp_hit = r_rd_vld && r_op == SCAN_LOW && r_q_kind == KIND_EMPTY
                     && !r_empty_vld;
    assign rd_hit  = r_rd_vld && r_op == SCAN_READ && r_q_kind == KIND_USED
                     && r_q_start <= r_item.sector && r_item.sector <= r_q_end
                     && !r_hit_vld;

    // write port selects
    logic          k_we, s_we, e_we, o_we;
    logic [IW-1:0] k_addr, s_addr;
    t_kind         k_data;
    logic [31:0]   s_data, e_data;
    logic          wr_new;

    assign wr_new = i_cmd.wr_tail || i_cmd.wr_split_a;

    always_comb begin
        k_we   = 1'b0;
        k_addr = r_empty_idx;
        k_data = KIND_USED;
        if (i_cmd.clr_run) begin
            k_we   = 1'b1;
            k_addr = r_cnt;
            k_data = KIND_EMPTY;
        end else if (del_hit) begin
            k_we   = 1'b1;
            k_addr = r_rd_idx;
            k_data = KIND_FREE;
        end else if (wr_new) begin
            k_we = 1'b1;
        end else if (i_cmd.wr_whole) begin
            k_we   = 1'b1;
            k_addr = r_best_idx;
        end
        s_we   = wr_new || i_cmd.wr_split_b;
        s_addr = i_cmd.wr_split_b ? r_best_idx : r_empty_idx;
        s_data = i_cmd.wr_tail    ? r_hw :
                 i_cmd.wr_split_b ? r_best_start + {16'd0, r_rem} : r_best_start;
        e_we   = wr_new;
        e_data = i_cmd.wr_tail ? tail_sum[31:0] - 32'd1 : new_end[31:0];
        o_we   = wr_new || i_cmd.wr_whole;
    end

    always_ff @(posedge i_clk) begin
        if (k_we) m_kind[k_addr] <= k_data;
        if (s_we) m_start[s_addr] <= s_data;
        if (e_we) m_end[r_empty_idx] <= e_data;
        if (o_we) m_owner[i_cmd.wr_whole ? r_best_idx : r_empty_idx] <= r_item.file_id;
        r_q_kind  <= m_kind[r_cnt];
        r_q_start <= m_start[r_cnt];
        r_q_end   <= m_end[r_cnt];
        r_q_owner <= m_owner[r_cnt];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_best_vld  <= 1'b0;
            r_empty_vld <= 1'b0;
            r_hit_vld   <= 1'b0;
            r_hw        <= '0;
            r_out_vld   <= 1'b0;
            r_op        <= SCAN_LOW;
        end else begin
            r_rd_vld <= i_cmd.scan_run;
            if (i_cmd.clr_run || i_cmd.scan_run) r_cnt <= r_cnt + 1'b1;
            if (i_cmd.scan_start) begin
                r_cnt      <= '0;
                r_op       <= i_cmd.op;
                r_best_vld <= 1'b0;
                r_hit_vld  <= 1'b0;
            end
            if (low_hit) r_best_vld <= 1'b1;
            if (emp_hit) r_empty_vld <= 1'b1;
            if (rd_hit) r_hit_vld <= 1'b1;
            if (i_cmd.load) r_empty_vld <= 1'b0;
            if (i_cmd.wr_tail) r_hw <= tail_sum[31:0];
            if (i_cmd.out_load) r_out_vld <= 1'b1;
            else if (i_out_ready) r_out_vld <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_cnt;
        if (i_cmd.load) begin
            r_item <= i_in_data;
            r_rem  <= i_in_data.length;
            r_lo   <= '0;
        end
        if (i_cmd.adv) begin
            r_rem <= r_rem - size[15:0];
            r_lo  <= {1'b0, r_best_end} + 33'd1;
        end
        if (i_cmd.exec_init) begin
            r_rem <= r_item.length;
            r_lo  <= '0;
        end
        if (low_hit) begin
            r_best_idx   <= r_rd_idx;
            r_best_start <= r_q_start;
            r_best_end   <= r_q_end;
        end
        if (emp_hit) r_empty_idx <= r_rd_idx;
        if (rd_hit) r_hit_owner <= r_q_owner;
        if (i_cmd.out_load) begin
            r_out.status <= i_cmd.out_status;
            r_out.owner  <= i_cmd.out_hit ? r_hit_owner : 32'd0;
        end
    end

    always_comb begin
        o_sts.clr_last  = r_cnt == LAST;
        o_sts.scan_last = r_cnt == LAST;
        o_sts.best_vld  = r_best_vld;
        o_sts.size_gt   = size > {17'd0, r_rem};
        o_sts.size_eq   = size == {17'd0, r_rem};
        o_sts.tail_ovf  = tail_sum[32];
        o_sts.empty_vld = r_empty_vld;
        o_sts.hit_vld   = r_hit_vld;
        o_sts.len_zero  = r_item.length == 16'd0;
        o_sts.item_cmd  = r_item.cmd;
        o_sts.out_busy  = r_out_vld && !i_out_ready;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_hw_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_tail |=> r_hw > $past(r_hw))
        else $error("high-water mark wrapped");
    a_new_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_tail || i_cmd.wr_split_a) |-> r_empty_vld)
        else $error("new extent written without an empty slot");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_vld || i_out_ready))
        else $error("result overwrote an unsent beat");

endmodule

// ===== sv/lowest_first_extent_allocator_unit.sv =====
// Lowest-first extent allocator for a linear disk of 32-bit sector addresses.
// Input channel (i_in_valid/o_in_ready/i_in_data): one command beat, either
// write (file id, length), delete (file id) or read (sector owner query).
// Output channel (o_out_valid/i_out_ready/o_out_data): one result beat per
// command with status (ok, not owned, table full) and the owner for reads.
// Walks: every table walk reads one extent per cycle from the table
// memories and runs through scan, drain and decide. Delete and read take
// one walk; the next command can be taken in the same cycle as their result
// beat becomes valid.
// A write takes one walk per free extent it touches, one more when it reaches
// the untouched tail, then, if it fits, the same walks again to commit; a
// split writes its second half in a separate split state. Zero-length writes
// and the unused command code skip the walk and go straight to the result beat.
// A new command is taken only once the previous one is finished; the result
// sits in an output register, so a stalled receiver only holds the next
// result back once that register is still full.
// Reset: synchronous, active low. After reset a clearing pass marks every
// table slot empty; o_in_ready stays low until the pass is over.
module lowest_first_extent_allocator_unit import lfea_pkg::*; #(
    parameter int MAX_EXTENTS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: clear pass, walks, feasibility/commit decisions
    lfea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // extent table memories, walk pipeline, result register
    lfea_dp #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
